/* hw/rtl/bwrp_pkg.sv */
package bwrp_pkg;

  localparam int PREFETCH_DEPTH = 8;
  localparam int FILL_W         = 4;
  localparam int CD_W           = 10;
  localparam int DUTY_W         = 4;
  localparam int CYC_W          = 5;
  localparam int IDLE_W         = 8;
  localparam int WC_W           = 16;
  localparam int PF_EN_BIT      = 14;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_IDLE   = 1'b1;

  localparam logic [1:0] AW_BYTE = 2'd0;
  localparam logic [1:0] AW_HALF = 2'd1;
  localparam logic [1:0] AW_WORD = 2'd2;

  // most negative countdown value, pending cycles held while the buffer is full
  localparam logic [CD_W-1:0] CD_MIN = {1'b1, {(CD_W-1){1'b0}}};

  typedef struct packed {
    logic [31:0] addr;
    logic        word;
    logic        seq;
    logic        vbusy;
  } acc_req_t;

  typedef struct packed {
    logic [CYC_W-1:0] cycles;
    logic             rom;
    logic             save;
  } acc_resp_t;

  function automatic logic [DUTY_W-1:0] first_wait(input logic [1:0] sel);
    logic [DUTY_W-1:0] w;
    unique case (sel)
      2'd0:    w = DUTY_W'(5);
      2'd1:    w = DUTY_W'(4);
      2'd2:    w = DUTY_W'(3);
      default: w = DUTY_W'(9);
    endcase
    return w;
  endfunction

  function automatic logic [1:0] rom_region(input logic [31:0] addr);
    return (addr[26:25] == 2'd3) ? 2'd2 : addr[26:25];
  endfunction

  function automatic logic [DUTY_W-1:0] seq_wait(input logic [WC_W-1:0] wc,
                                                 input logic [1:0] region);
    logic              fast;
    logic [DUTY_W-1:0] slow;
    unique case (region)
      2'd0: begin
        fast = wc[4];
        slow = DUTY_W'(3);
      end
      2'd1: begin
        fast = wc[7];
        slow = DUTY_W'(5);
      end
      default: begin
        fast = wc[10];
        slow = DUTY_W'(9);
      end
    endcase
    return fast ? DUTY_W'(2) : slow;
  endfunction

  function automatic logic [1:0] first_sel(input logic [WC_W-1:0] wc, input logic [1:0] region);
    logic [1:0] s;
    unique case (region)
      2'd0:    s = wc[3:2];
      2'd1:    s = wc[6:5];
      default: s = wc[9:8];
    endcase
    return s;
  endfunction

  function automatic logic is_rom(input logic [31:0] addr);
    return (addr[31:28] == 4'd0) && addr[27] && (addr[26:25] != 2'b11);
  endfunction

  function automatic logic is_save(input logic [31:0] addr);
    return addr[31:25] == 7'b0000111;
  endfunction

endpackage

/* hw/rtl/bus_wait_state_and_rom_prefetch.sv */
// channel  direction  ports
// in       input      in_valid, in_ready, in_cmd, in_address, in_access_width, in_is_write,
//                     in_code_fetch, in_sequential, in_video_busy, in_idle_cycles
// out      output     out_valid, out_ready, out_wait_cycles, out_prefetch_hit,
//                     out_buffered_count
// cfg      input      cfg_valid, cfg_ready, cfg_data
//
// an idle item with the buffer on, and a buffer hit, go on to a fill loop that adds one
// halfword per cycle while the countdown is not positive, up to 8 halfwords; the loop
// steps the countdown by the sequential wait as it fills
// rst_n is synchronous, active low; the buffer comes up stopped and empty
// a finished result waits in the output register while the next item is taken, and a
// result still held with out_ready low stalls the next item in its last step;
// in_ready is low while an item is at work, and while a config write is offered
module bus_wait_state_and_rom_prefetch (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [31:0]                    in_address,
  input  logic [1:0]                     in_access_width,
  input  logic                           in_is_write,
  input  logic                           in_code_fetch,
  input  logic                           in_sequential,
  input  logic                           in_video_busy,
  input  logic [bwrp_pkg::IDLE_W-1:0]    in_idle_cycles,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bwrp_pkg::CYC_W-1:0]     out_wait_cycles,
  output logic                           out_prefetch_hit,
  output logic [bwrp_pkg::FILL_W-1:0]    out_buffered_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bwrp_pkg::WC_W-1:0]      cfg_data
);

  localparam int FillW = bwrp_pkg::FILL_W;
  localparam int CdW   = bwrp_pkg::CD_W;
  localparam int DutyW = bwrp_pkg::DUTY_W;
  localparam int CycW  = bwrp_pkg::CYC_W;
  localparam int IdleW = bwrp_pkg::IDLE_W;
  localparam logic [FillW-1:0] Depth   = FillW'(bwrp_pkg::PREFETCH_DEPTH);
  localparam logic [FillW-1:0] DepthM1 = FillW'(bwrp_pkg::PREFETCH_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_FILL, S_DONE} state_t;

  state_t                 state_r;
  logic [bwrp_pkg::WC_W-1:0] wc_r;
  logic                   pf_on_r;
  logic [31:0]            head_r;
  logic [FillW-1:0]       fill_r;
  logic [DutyW-1:0]       duty_r;
  logic [CdW-1:0]         cd_r;

  logic                   cmd_r;
  logic [31:0]            addr_r;
  logic                   word_r;
  logic                   half_r;
  logic                   wr_r;
  logic                   code_r;
  logic                   seq_r;
  logic                   vbusy_r;
  logic [IdleW-1:0]       idle_r;

  logic [CycW-1:0]        res_cyc_r;
  logic                   res_hit_r;

  logic                   out_valid_r;
  logic [CycW-1:0]        cyc_r;
  logic                   hit_r;
  logic [FillW-1:0]       cnt_out_r;

  bwrp_pkg::acc_req_t     req;
  bwrp_pkg::acc_resp_t    resp;

  logic [FillW-1:0]       need;
  logic                   hit;
  logic [31:0]            next_addr;
  logic [DutyW-1:0]       next_duty;
  logic [IdleW-1:0]       sub_amt;
  logic [CdW:0]           cd_sub;
  logic [CdW-1:0]         cd_sat;
  logic                   cd_le0;

  bwrp_access_timing u_timing (
    .wait_control (wc_r),
    .req          (req),
    .resp         (resp)
  );

  assign req.addr  = addr_r;
  assign req.word  = word_r;
  assign req.seq   = seq_r;
  assign req.vbusy = vbusy_r;

  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);

  assign out_valid          = out_valid_r;
  assign out_wait_cycles    = cyc_r;
  assign out_prefetch_hit   = hit_r;
  assign out_buffered_count = cnt_out_r;

  always_comb begin
    need      = word_r ? FillW'(2) : FillW'(1);
    hit       = code_r && pf_on_r && (head_r == addr_r) && (fill_r >= need);
    next_addr = addr_r + (word_r ? 32'd4 : (half_r ? 32'd2 : 32'd1));
    next_duty = bwrp_pkg::seq_wait(wc_r, bwrp_pkg::rom_region(next_addr));
    sub_amt   = (cmd_r == bwrp_pkg::CMD_IDLE) ? idle_r : IdleW'(1);
    cd_sub    = {cd_r[CdW-1], cd_r} - (CdW+1)'(sub_amt);
    // clamp when the difference drops below the countdown floor
    cd_sat    = (cd_sub[CdW] != cd_sub[CdW-1]) ? bwrp_pkg::CD_MIN : cd_sub[CdW-1:0];
    cd_le0    = cd_r[CdW-1] || (cd_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wc_r        <= '0;
      pf_on_r     <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
      duty_r      <= '0;
      cd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            wc_r <= cfg_data;
            if (pf_on_r) begin
              duty_r <= bwrp_pkg::seq_wait(cfg_data, bwrp_pkg::rom_region(head_r));
            end
            if (!cfg_data[bwrp_pkg::PF_EN_BIT]) begin
              pf_on_r <= 1'b0;
              fill_r  <= '0;
            end
          end else if (in_valid) begin
            cmd_r   <= in_cmd;
            addr_r  <= in_address;
            word_r  <= in_access_width[1];
            half_r  <= (in_access_width == bwrp_pkg::AW_HALF);
            wr_r    <= in_is_write;
            code_r  <= in_code_fetch;
            seq_r   <= in_sequential;
            vbusy_r <= in_video_busy;
            idle_r  <= in_idle_cycles;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (cmd_r == bwrp_pkg::CMD_IDLE) begin
            res_cyc_r <= '0;
            res_hit_r <= 1'b0;
            if (pf_on_r) begin
              cd_r    <= cd_sat;
              state_r <= S_FILL;
            end else begin
              state_r <= S_DONE;
            end
          end else if (resp.rom && !wr_r && hit) begin
            res_cyc_r <= CycW'(1);
            res_hit_r <= 1'b1;
            fill_r    <= fill_r - need;
            head_r    <= head_r + (word_r ? 32'd4 : 32'd2);
            cd_r      <= cd_sat;
            state_r   <= S_FILL;
          end else begin
            res_cyc_r <= resp.cycles;
            res_hit_r <= 1'b0;
            state_r   <= S_DONE;
            if (resp.rom && !wr_r) begin
              if (code_r && wc_r[bwrp_pkg::PF_EN_BIT]) begin
                pf_on_r <= 1'b1;
                head_r  <= next_addr;
                fill_r  <= '0;
                duty_r  <= next_duty;
                cd_r    <= {{(CdW-DutyW){1'b0}}, next_duty};
              end else begin
                pf_on_r <= 1'b0;
                fill_r  <= '0;
              end
            end else if (resp.save) begin
              pf_on_r <= 1'b0;
              fill_r  <= '0;
            end
          end
        end
        S_FILL: begin
          if (cd_le0 && (fill_r < Depth)) begin
            fill_r <= fill_r + FillW'(1);
            if (fill_r < DepthM1) begin
              cd_r <= cd_r + {{(CdW-DutyW){1'b0}}, duty_r};
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            cyc_r       <= res_cyc_r;
            hit_r       <= res_hit_r;
            cnt_out_r   <= fill_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/bwrp_access_timing.sv */
module bwrp_access_timing (
  input  logic [bwrp_pkg::WC_W-1:0] wait_control,
  input  bwrp_pkg::acc_req_t        req,
  output bwrp_pkg::acc_resp_t       resp
);

  localparam int CycW = bwrp_pkg::CYC_W;

  logic [3:0]                       top;
  logic [1:0]                       region;
  logic [bwrp_pkg::DUTY_W-1:0]      seqw;
  logic [bwrp_pkg::DUTY_W-1:0]      firstw;
  logic [CycW-1:0]                  half_c;

  always_comb begin
    top    = req.addr[27:24];
    region = bwrp_pkg::rom_region(req.addr);
    seqw   = bwrp_pkg::seq_wait(wait_control, region);
    firstw = bwrp_pkg::first_wait(bwrp_pkg::first_sel(wait_control, region));
    half_c = req.seq ? {1'b0, seqw} : {1'b0, firstw};

    resp.rom  = bwrp_pkg::is_rom(req.addr);
    resp.save = bwrp_pkg::is_save(req.addr);

    priority if (req.addr[31:14] == 18'd0) begin
      resp.cycles = CycW'(1);
    end else if (top == 4'd2) begin
      resp.cycles = req.word ? CycW'(6) : CycW'(3);
    end else if (top == 4'd3 || top == 4'd4) begin
      resp.cycles = CycW'(1);
    end else if (top == 4'd5 || top == 4'd6 || top == 4'd7) begin
      resp.cycles = (req.word ? CycW'(2) : CycW'(1)) + CycW'(req.vbusy);
    end else if (resp.rom) begin
      resp.cycles = req.word ? (half_c + {1'b0, seqw}) : half_c;
    end else if (resp.save) begin
      resp.cycles = {1'b0, bwrp_pkg::first_wait(wait_control[1:0])};
    end else begin
      resp.cycles = CycW'(1);
    end
  end

endmodule

/* hw/rtl/bwrp_checker.sv */
module bwrp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bwrp_pkg::CYC_W-1:0]  out_wait_cycles,
  input logic                        out_prefetch_hit,
  input logic [bwrp_pkg::FILL_W-1:0] out_buffered_count
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_wait_cycles)
      && $stable(out_prefetch_hit) && $stable(out_buffered_count))
    else $error("result changed while stalled");

  // in_ready drops after an item is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted back to back");

  // a buffer hit always costs one cycle
  a_hit_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prefetch_hit |-> out_wait_cycles == bwrp_pkg::CYC_W'(1))
    else $error("hit with wrong cycle count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_buffered_count <= bwrp_pkg::FILL_W'(bwrp_pkg::PREFETCH_DEPTH))
    else $error("buffered count above depth");

  // idle items report no cycles and never hit
  a_idle_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_wait_cycles == '0) |-> !out_prefetch_hit)
    else $error("hit on idle item");

endmodule

bind bus_wait_state_and_rom_prefetch bwrp_checker u_bwrp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_wait_cycles    (out_wait_cycles),
  .out_prefetch_hit   (out_prefetch_hit),
  .out_buffered_count (out_buffered_count)
);
